// File: src/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg: shared types and constants of the quaternion to Euler angle unit
// Widths of the internal terms, the CORDIC arctangent table and the constants
// of the angle unit conversion.
// ----------------------------------------------------------------------------
`default_nettype none

package qte_pkg;

   localparam int QW                    = 16;  // quaternion component width
   localparam int OW                    = 16;  // angle result width
   localparam int TW                    = 34;  // term width (2^30 scaled)
   localparam int T3W                   = 32;  // clamped asin term width
   localparam int RADW                  = 62;  // radicand width of 1 - s^2
   localparam int ROOTW                 = 31;  // square root width
   localparam int REMW                  = 34;  // square root remainder width
   localparam int CW                    = 37;  // CORDIC x/y width
   localparam int ZW                    = 35;  // CORDIC angle width
   localparam int TAB_LEN               = 24;  // entries in the arctangent table
   localparam int CORDIC_ITERATIONS_DEF = 16;
   localparam int MAGW                  = 33;  // clamped angle magnitude width
   localparam int NUMW                  = 48;  // degree numerator width
   localparam int RQW                   = 17;  // unsaturated quotient width
   localparam int HALFW                 = 24;  // half of the numerator split
   localparam int PW                    = 41;  // partial product width

   localparam logic [31:0]           PI30      = 32'd3373259426;  // pi * 2^30
   localparam logic [31:0]           HALF_PI30 = 32'd1686629713;  // PI30 / 2
   localparam logic signed [TW-1:0]  ONE30_T   = 34'sd1073741824;
   localparam logic [RADW-1:0]       ONE60     = 62'd1 << 60;
   localparam logic [14:0]           DEG_SCALE = 15'd23040;       // 180 * 128
   localparam logic [RQW-1:0]        RECIP     = 17'd83444;       // ceil(2^48/PI30)

   typedef struct packed {
      logic signed [TW-1:0]  t1;       // heading numerator
      logic signed [TW-1:0]  t2;       // heading denominator
      logic signed [TW-1:0]  t4;       // pitch numerator
      logic signed [TW-1:0]  t5;       // pitch denominator
      logic signed [T3W-1:0] t3;       // clamped asin argument
      logic                  clamped;
   } side_type;

   // arctangent of 2^-i, radians scaled by 2^30
   function automatic logic [30:0] atan_entry(input int unsigned idx);
      logic [30:0] r;
      case (idx)
         0:  r = 31'd843314857;
         1:  r = 31'd497837830;
         2:  r = 31'd263043837;
         3:  r = 31'd133525159;
         4:  r = 31'd67021687;
         5:  r = 31'd33543516;
         6:  r = 31'd16775851;
         7:  r = 31'd8388437;
         8:  r = 31'd4194283;
         9:  r = 31'd2097149;
         10: r = 31'd1048576;
         11: r = 31'd524288;
         12: r = 31'd262144;
         13: r = 31'd131072;
         14: r = 31'd65536;
         15: r = 31'd32768;
         16: r = 31'd16384;
         17: r = 31'd8192;
         18: r = 31'd4096;
         19: r = 31'd2048;
         20: r = 31'd1024;
         21: r = 31'd512;
         22: r = 31'd256;
         23: r = 31'd128;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// File: src/qte_terms.sv
// ----------------------------------------------------------------------------
// qte_terms: product and term stages
// Four stages: component products, the five angle terms with the asin clamp,
// the square of the clamped term, and the radicand 1 - s^2.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_terms import qte_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic                 in_valid,
   input  wire logic signed [QW-1:0] qx,
   input  wire logic signed [QW-1:0] qy,
   input  wire logic signed [QW-1:0] qz,
   input  wire logic signed [QW-1:0] qw,
   output      logic                 out_valid,
   output      side_type             out_side,
   output      logic [RADW-1:0]      out_rad
);

   logic signed [31:0] xx_ff, yy_ff, zz_ff, ww_ff, xy_ff, wz_ff, xz_ff, wy_ff, wx_ff, yz_ff;
   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   side_type           s2_ff, s3_ff, s4_ff, s2_in;
   logic signed [TW-1:0] t3_raw;
   logic [T3W-2:0]     mag3;
   logic [RADW-1:0]    sq_ff, sq_in, rad_ff;

   // stage 1: products
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (en) v1_ff <= in_valid;
      if (en) begin
         xx_ff <= 32'(qx) * 32'(qx);
         yy_ff <= 32'(qy) * 32'(qy);
         zz_ff <= 32'(qz) * 32'(qz);
         ww_ff <= 32'(qw) * 32'(qw);
         xy_ff <= 32'(qx) * 32'(qy);
         wz_ff <= 32'(qw) * 32'(qz);
         xz_ff <= 32'(qx) * 32'(qz);
         wy_ff <= 32'(qw) * 32'(qy);
         wx_ff <= 32'(qw) * 32'(qx);
         yz_ff <= 32'(qy) * 32'(qz);
      end
   end

   // stage 2: terms, saturate the asin argument to one
   always_comb begin
      s2_in.t1 = (TW'(xy_ff) + TW'(wz_ff)) <<< 1;
      s2_in.t2 = TW'(ww_ff) + TW'(xx_ff) - TW'(yy_ff) - TW'(zz_ff);
      s2_in.t4 = (TW'(wx_ff) + TW'(yz_ff)) <<< 1;
      s2_in.t5 = TW'(ww_ff) - TW'(xx_ff) - TW'(yy_ff) + TW'(zz_ff);
      t3_raw   = (TW'(wy_ff) - TW'(xz_ff)) <<< 1;
      s2_in.clamped = 1'b0;
      if (t3_raw > ONE30_T) begin
         s2_in.t3      = T3W'(ONE30_T);
         s2_in.clamped = 1'b1;
      end else if (t3_raw < -ONE30_T) begin
         s2_in.t3      = T3W'(-ONE30_T);
         s2_in.clamped = 1'b1;
      end else begin
         s2_in.t3 = T3W'(t3_raw);
      end
   end

   // stage 3: square of the magnitude; the magnitude is at most 2^30, the square at most 2^60
   assign mag3  = s2_ff.t3[T3W-1] ? (T3W-1)'(-s2_ff.t3) : s2_ff.t3[T3W-2:0];
   assign sq_in = RADW'(mag3) * RADW'(mag3);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      if (en) begin
         s2_ff  <= s2_in;
         s3_ff  <= s2_ff;
         sq_ff  <= sq_in;
         s4_ff  <= s3_ff;
         rad_ff <= ONE60 - sq_ff;
      end
   end

   assign out_valid = v4_ff;
   assign out_side  = s4_ff;
   assign out_rad   = rad_ff;

endmodule

`default_nettype wire

// File: src/qte_isqrt.sv
// ----------------------------------------------------------------------------
// qte_isqrt: pipelined floor square root
// One result bit per stage, restoring digit method; the angle terms ride along.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_isqrt import qte_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             in_valid,
   input  wire side_type         in_side,
   input  wire logic [RADW-1:0]  in_rad,
   output      logic             out_valid,
   output      side_type         out_side,
   output      logic [ROOTW-1:0] out_root
);

   localparam int NQ = ROOTW;

   logic [REMW-1:0]  rem_ff  [1:NQ];
   logic [ROOTW-1:0] root_ff [1:NQ];
   logic [RADW-1:0]  n_ff    [1:NQ];
   side_type         side_ff [1:NQ];
   logic             vld_ff  [1:NQ];

   for (genvar j = 0; j < NQ; j++) begin : g_step
      logic [REMW-1:0]  rem_src, cur, trial, rem_in;
      logic [ROOTW-1:0] root_src, root_in;
      logic [RADW-1:0]  n_src;
      side_type         side_src;
      logic             vld_src, ge;

      if (j == 0) begin : g_first
         assign rem_src  = '0;
         assign root_src = '0;
         assign n_src    = in_rad;
         assign side_src = in_side;
         assign vld_src  = in_valid;
      end else begin : g_next
         assign rem_src  = rem_ff[j];
         assign root_src = root_ff[j];
         assign n_src    = n_ff[j];
         assign side_src = side_ff[j];
         assign vld_src  = vld_ff[j];
      end

      // bring down two radicand bits, try root*4 + 1
      assign cur     = {rem_src[REMW-3:0], n_src[RADW-1 -: 2]};
      assign trial   = REMW'({root_src, 2'b01});
      assign ge      = cur >= trial;
      assign rem_in  = ge ? cur - trial : cur;
      assign root_in = {root_src[ROOTW-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) vld_ff[j+1] <= 1'b0;
         else if (en) vld_ff[j+1] <= vld_src;
         if (en) begin
            rem_ff[j+1]  <= rem_in;
            root_ff[j+1] <= root_in;
            n_ff[j+1]    <= n_src << 2;
            side_ff[j+1] <= side_src;
         end
      end
   end

   assign out_valid = vld_ff[NQ];
   assign out_side  = side_ff[NQ];
   assign out_root  = root_ff[NQ];

endmodule

`default_nettype wire

// File: src/qte_cordic.sv
// ----------------------------------------------------------------------------
// qte_cordic: pipelined vectoring CORDIC for atan2
// A fold stage maps the left half plane onto the right one, then one
// micro-rotation per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_cordic import qte_pkg::*; #(
   parameter int ITER = CORDIC_ITERATIONS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic                 in_valid,
   input  wire logic signed [TW-1:0] in_y,
   input  wire logic signed [TW-1:0] in_x,
   input  wire logic                 in_tag,
   output      logic                 out_valid,
   output      logic signed [ZW-1:0] out_z,
   output      logic                 out_tag
);

   localparam int NSTEP = (ITER > TAB_LEN) ? TAB_LEN : ITER;

   logic signed [CW-1:0] x_ff [0:NSTEP];
   logic signed [CW-1:0] y_ff [0:NSTEP];
   logic signed [ZW-1:0] z_ff [0:NSTEP];
   logic                 vld_ff  [0:NSTEP];
   logic                 zero_ff [0:NSTEP];
   logic                 tag_ff  [0:NSTEP];
   logic signed [CW-1:0] xe, ye;

   assign xe = CW'(in_x);
   assign ye = CW'(in_y);

   // fold: negate the vector and start at +pi or -pi for x < 0
   always_ff @(posedge clock) begin
      if (reset) vld_ff[0] <= 1'b0;
      else if (en) vld_ff[0] <= in_valid;
      if (en) begin
         zero_ff[0] <= (in_x == '0) && (in_y == '0);
         tag_ff[0]  <= in_tag;
         if (in_x[TW-1]) begin
            x_ff[0] <= -xe;
            y_ff[0] <= -ye;
            z_ff[0] <= in_y[TW-1] ? -ZW'(PI30) : ZW'(PI30);
         end else begin
            x_ff[0] <= xe;
            y_ff[0] <= ye;
            z_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < NSTEP; i++) begin : g_step
      logic signed [CW-1:0] dx, dy, x_in, y_in;
      logic signed [ZW-1:0] ang, z_in;

      assign dx  = x_ff[i] >>> i;
      assign dy  = y_ff[i] >>> i;
      assign ang = ZW'(atan_entry(i));

      // rotate toward the x axis
      always_comb begin
         if (y_ff[i][CW-1]) begin
            x_in = x_ff[i] - dy;
            y_in = y_ff[i] + dx;
            z_in = z_ff[i] - ang;
         end else begin
            x_in = x_ff[i] + dy;
            y_in = y_ff[i] - dx;
            z_in = z_ff[i] + ang;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) vld_ff[i+1] <= 1'b0;
         else if (en) vld_ff[i+1] <= vld_ff[i];
         if (en) begin
            x_ff[i+1]    <= x_in;
            y_ff[i+1]    <= y_in;
            z_ff[i+1]    <= z_in;
            zero_ff[i+1] <= zero_ff[i];
            tag_ff[i+1]  <= tag_ff[i];
         end
      end
   end

   assign out_valid = vld_ff[NSTEP];
   assign out_z     = zero_ff[NSTEP] ? '0 : z_ff[NSTEP];
   assign out_tag   = tag_ff[NSTEP];

`ifndef SYNTHESIS
   // x only grows once the vector is folded into the right half plane
   a_x_nonneg: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NSTEP] |-> !x_ff[NSTEP][CW-1])
      else $error("CORDIC x went negative");
`endif

endmodule

`default_nettype wire

// File: src/qte_unit.sv
// ----------------------------------------------------------------------------
// qte_unit: angle unit conversion
// Rounds the 2^30 scaled angle to radians * 8192 or to degrees * 128 and
// saturates to 16 bits. Degrees use a reciprocal multiply with one correction.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_unit import qte_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic                 in_valid,
   input  wire logic signed [ZW-1:0] in_z,
   input  wire logic                 in_tag,
   input  wire logic                 mode_deg,
   output      logic                 out_valid,
   output      logic signed [OW-1:0] out_angle,
   output      logic                 out_tag
);

   localparam int PRW = RQW + 32;

   logic [ZW-1:0]    mag_full;
   logic [MAGW-1:0]  magc;
   logic [MAGW:0]    rad_sum;
   logic [NUMW-1:0]  a_n_in, a_n_ff, b_n_ff, c_n_ff;
   logic [RQW-1:0]   a_rad_ff, b_rad_ff, c_rad_ff, c_q_ff, deg_q, q;
   logic             a_neg_ff, b_neg_ff, c_neg_ff;
   logic             a_tag_ff, b_tag_ff, c_tag_ff, tag_ff;
   logic             a_v_ff, b_v_ff, c_v_ff, d_v_ff;
   logic [PW-1:0]    plo_ff, phi_ff;
   logic [PW+HALFW-1:0] psum;
   logic [PRW-1:0]   prod;
   logic signed [OW-1:0] angle_in, angle_ff;

   // stage A: magnitude, clamp (anything clamped still saturates), numerator
   assign mag_full = in_z[ZW-1] ? ZW'(-in_z) : ZW'(in_z);
   assign magc     = (mag_full >= (ZW'(1) << MAGW)) ? '1 : mag_full[MAGW-1:0];
   assign rad_sum  = (MAGW+1)'(magc) + (MAGW+1)'(65536);
   assign a_n_in   = NUMW'(magc) * NUMW'(DEG_SCALE) + NUMW'(HALF_PI30);

   // stage C: quotient estimate, equal to the quotient or one above
   assign psum = {phi_ff, HALFW'(0)} + (PW+HALFW)'(plo_ff);

   // stage D: correct, select unit, saturate, restore sign
   assign prod  = PRW'(c_q_ff) * PRW'(PI30);
   assign deg_q = (prod > PRW'(c_n_ff)) ? c_q_ff - RQW'(1) : c_q_ff;
   assign q     = mode_deg ? deg_q : c_rad_ff;

   always_comb begin
      if (!c_neg_ff) begin
         angle_in = (q > RQW'(32767)) ? OW'(32767) : OW'(q);
      end else begin
         angle_in = (q > RQW'(32768)) ? OW'(-32768) : OW'(-q);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
      end else if (en) begin
         a_v_ff <= in_valid;
         b_v_ff <= a_v_ff;
         c_v_ff <= b_v_ff;
         d_v_ff <= c_v_ff;
      end
      if (en) begin
         a_neg_ff <= in_z[ZW-1];
         a_tag_ff <= in_tag;
         a_n_ff   <= a_n_in;
         a_rad_ff <= rad_sum[MAGW:MAGW-RQW+1];
         plo_ff   <= PW'(a_n_ff[HALFW-1:0]) * PW'(RECIP);
         phi_ff   <= PW'(a_n_ff[NUMW-1:HALFW]) * PW'(RECIP);
         b_n_ff   <= a_n_ff;
         b_rad_ff <= a_rad_ff;
         b_neg_ff <= a_neg_ff;
         b_tag_ff <= a_tag_ff;
         c_q_ff   <= psum[PW+HALFW-1:NUMW];
         c_n_ff   <= b_n_ff;
         c_rad_ff <= b_rad_ff;
         c_neg_ff <= b_neg_ff;
         c_tag_ff <= b_tag_ff;
         angle_ff <= angle_in;
         tag_ff   <= c_tag_ff;
      end
   end

   assign out_valid = d_v_ff;
   assign out_angle = angle_ff;
   assign out_tag   = tag_ff;

`ifndef SYNTHESIS
   // reciprocal estimate overshoots by at most one quotient step
   a_recip_bound: assert property (@(posedge clock) disable iff (reset)
      c_v_ff |-> prod <= PRW'(c_n_ff) + PRW'(PI30))
      else $error("degree quotient estimate out of bound");
`endif

endmodule

`default_nettype wire

// File: src/quaternion_to_euler_angles_unit.sv
// Pipeline from req word to rsp word: 4 term stages, 31 square root stages,
//   1 + min(CORDIC_ITERATIONS, TAB_LEN) CORDIC stages, 4 unit stages.
// Throughput: one word per cycle; every stage is a register, and the whole pipeline
//   holds while a finished rsp word waits.
// Reset: synchronous, clears the stage valid bits and sets the unit to radians.
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_unit: quaternion to heading, pitch and roll
// Three CORDIC atan2 pipelines; roll is asin(s) = atan2(s, sqrt(1 - s^2)).
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_to_euler_angles_unit import qte_pkg::*; #(
   parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   // req word
   input  wire logic          req_tvalid,
   output      logic          req_tready,
   input  wire logic [63:0]   req_tdata,   // quat_x, quat_y, quat_z, quat_w
   // rsp word
   output      logic          rsp_tvalid,
   input  wire logic          rsp_tready,
   output      logic [47:0]   rsp_tdata,   // heading_angle, pitch_angle, roll_angle
   output      logic [0:0]    rsp_tuser,   // asin_clamped
   // unit select register
   input  wire logic          csr_valid,
   output      logic          csr_ready,
   input  wire logic [0:0]    csr_data     // output_in_degrees
);

   logic                 deg_ff;
   logic                 en;
   logic                 tm_valid, sq_valid;
   side_type             tm_side, sq_side;
   logic [RADW-1:0]      tm_rad;
   logic [ROOTW-1:0]     sq_root;
   logic                 hc_valid, pc_valid, rc_valid, rc_tag;
   logic signed [ZW-1:0] hc_z, pc_z, rc_z;
   logic                 hu_valid, pu_valid, ru_valid, ru_tag;
   logic signed [OW-1:0] hu_angle, pu_angle, ru_angle;

   // unit register; the user must write it only while the pipeline is empty, the block does not enforce this
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) deg_ff <= 1'b0;
      else if (csr_valid) deg_ff <= csr_data[0];
   end

   // advance every stage unless a finished word is held at the output
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   qte_terms u_terms (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .qx        (req_tdata[15:0]),
      .qy        (req_tdata[31:16]),
      .qz        (req_tdata[47:32]),
      .qw        (req_tdata[63:48]),
      .out_valid (tm_valid),
      .out_side  (tm_side),
      .out_rad   (tm_rad)
   );

   qte_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (tm_valid),
      .in_side   (tm_side),
      .in_rad    (tm_rad),
      .out_valid (sq_valid),
      .out_side  (sq_side),
      .out_root  (sq_root)
   );

   // heading and pitch ride through the square root stages with the roll term
   qte_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_hd (
      .clock (clock), .reset (reset), .en (en),
      .in_valid (sq_valid), .in_y (sq_side.t1), .in_x (sq_side.t2), .in_tag (1'b0),
      .out_valid (hc_valid), .out_z (hc_z), .out_tag ()
   );

   qte_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_pt (
      .clock (clock), .reset (reset), .en (en),
      .in_valid (sq_valid), .in_y (sq_side.t4), .in_x (sq_side.t5), .in_tag (1'b0),
      .out_valid (pc_valid), .out_z (pc_z), .out_tag ()
   );

   // the clamp flag travels with roll
   qte_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_rl (
      .clock (clock), .reset (reset), .en (en),
      .in_valid (sq_valid), .in_y (TW'(sq_side.t3)), .in_x (TW'(sq_root)),
      .in_tag (sq_side.clamped),
      .out_valid (rc_valid), .out_z (rc_z), .out_tag (rc_tag)
   );

   qte_unit u_unit_hd (
      .clock (clock), .reset (reset), .en (en),
      .in_valid (hc_valid), .in_z (hc_z), .in_tag (1'b0), .mode_deg (deg_ff),
      .out_valid (hu_valid), .out_angle (hu_angle), .out_tag ()
   );

   qte_unit u_unit_pt (
      .clock (clock), .reset (reset), .en (en),
      .in_valid (pc_valid), .in_z (pc_z), .in_tag (1'b0), .mode_deg (deg_ff),
      .out_valid (pu_valid), .out_angle (pu_angle), .out_tag ()
   );

   qte_unit u_unit_rl (
      .clock (clock), .reset (reset), .en (en),
      .in_valid (rc_valid), .in_z (rc_z), .in_tag (rc_tag), .mode_deg (deg_ff),
      .out_valid (ru_valid), .out_angle (ru_angle), .out_tag (ru_tag)
   );

   assign rsp_tvalid   = hu_valid;
   assign rsp_tdata    = {ru_angle, pu_angle, hu_angle};
   assign rsp_tuser[0] = ru_tag;

`ifndef SYNTHESIS
   // the three angle pipelines stay in lockstep
   a_lockstep: assert property (@(posedge clock) disable iff (reset)
      (hu_valid == pu_valid) && (hu_valid == ru_valid))
      else $error("angle pipelines out of step");

   // a held rsp word freezes the input side
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while output stalled");

   // a held rsp word keeps its flag
   a_flag_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tuser))
      else $error("clamp flag changed under stall");
`endif

endmodule

`default_nettype wire
